[hdl/cma_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants for the calendar minute advance pipeline.
// -----------------------------------------------------------------------------
package cma_pkg;

	localparam int unsigned MinPerHour   = 60;
	localparam int unsigned MinPerDay    = 1440;
	localparam int unsigned DefaultYear  = 2024;
	localparam int unsigned MonthsInYear = 12;

	// Width of hour*60 + minute + add_minutes (max 67458)
	localparam int unsigned TotalW = 17;
	// Width of whole days carried out of the minute sum (max 46)
	localparam int unsigned DaysW  = 6;
	// Width of minutes since midnight
	localparam int unsigned MdayW  = 11;

	// Input transaction
	typedef struct packed {
		logic [4:0]  day_in;
		logic [3:0]  month_in;
		logic [15:0] year_in;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [15:0] add_minutes;
	} cma_in_t;

	// Result transaction
	typedef struct packed {
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [15:0] year_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
	} cma_out_t;

	// Validated calendar date
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
	} cma_date_t;

	// Front stage control and minute sum
	typedef struct packed {
		logic              vld;
		logic [TotalW-1:0] total;
	} cma_sum_t;

endpackage

[hdl/cma_front.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cma_front
// Stage 1: date validation, default substitution and the minute sum.
// -----------------------------------------------------------------------------
module cma_front import cma_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cma_in_t   item,
	output cma_sum_t  sum,
	output cma_date_t date
);

	logic      bad_date;
	cma_date_t date_d;
	logic [4:0] hour_d;
	logic [5:0] minute_d;
	logic [TotalW-1:0] total_d;
	logic      vld_s1;
	logic [TotalW-1:0] total_s1;
	cma_date_t date_s1;

	// Invalid dates fall back to 1 Jan 2024 00:00
	assign bad_date = (item.day_in == 5'd0) || (item.month_in == 4'd0) ||
			(item.month_in > 4'(MonthsInYear)) || (item.year_in == 16'd0);

	always_comb begin
		if (bad_date) begin
			date_d.day   = 5'd1;
			date_d.month = 4'd1;
			date_d.year  = 16'(DefaultYear);
			hour_d       = 5'd0;
			minute_d     = 6'd0;
		end else begin
			date_d.day   = item.day_in;
			date_d.month = item.month_in;
			date_d.year  = item.year_in;
			hour_d       = item.hour_in;
			minute_d     = item.minute_in;
		end
	end

	// hour*60 + minute + add, no range check on hour or minute
	assign total_d = TotalW'(hour_d) * TotalW'(MinPerHour) + TotalW'(minute_d) +
			TotalW'(item.add_minutes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		total_s1 <= total_d;
		date_s1  <= date_d;
	end

	assign sum.vld   = vld_s1;
	assign sum.total = total_s1;
	assign date      = date_s1;

endmodule

[hdl/cma_day_split.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cma_day_split
// Stages 2-5: splits the minute sum into whole days, hour and minute using
// reciprocal multiplies.
// -----------------------------------------------------------------------------
module cma_day_split import cma_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cma_sum_t         sum,
	output logic [DaysW-1:0] days,
	output logic             vld,
	output logic [4:0]       hour,
	output logic [5:0]       minute
);

	// 1440 = 32 * 45: shift off five bits, then divide by 45
	localparam int unsigned LowW     = 5;
	localparam int unsigned DayOdd   = MinPerDay >> LowW;
	localparam int unsigned QW       = TotalW - LowW;
	localparam int unsigned RecShift = 17;
	localparam int unsigned DayRecip = ((1 << RecShift) + DayOdd - 1) / DayOdd;
	localparam int unsigned HourRecip = ((1 << RecShift) + MinPerHour - 1) / MinPerHour;
	localparam int unsigned DayProdW  = QW + 12;
	localparam int unsigned HourProdW = MdayW + 12;

	logic                 vld_s2, vld_s3, vld_s4, vld_s5;
	logic [QW-1:0]        q_s2;
	logic [LowW-1:0]      low_s2;
	logic [DaysW-1:0]     days_s2;
	logic [MdayW-1:0]     mday_s3, mday_s4;
	logic [4:0]           hour_s4, hour_s5;
	logic [5:0]           minute_s5;
	logic [DayProdW-1:0]  day_prod;
	logic [QW-1:0]        rem45;
	logic [HourProdW-1:0] hour_prod;
	logic [MdayW-1:0]     min_rem;

	// Stage 2: days = (total >> 5) / 45
	assign day_prod = DayProdW'(sum.total[TotalW-1:LowW]) * DayProdW'(DayRecip);

	// Stage 3: remainder rebuilt into minutes since midnight
	assign rem45 = q_s2 - QW'(days_s2) * QW'(DayOdd);

	// Stage 4: hour = mday / 60
	assign hour_prod = HourProdW'(mday_s3) * HourProdW'(HourRecip);

	// Stage 5: minute = mday - hour*60
	assign min_rem = mday_s4 - MdayW'(hour_s4) * MdayW'(MinPerHour);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= sum.vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		q_s2      <= sum.total[TotalW-1:LowW];
		low_s2    <= sum.total[LowW-1:0];
		days_s2   <= DaysW'(day_prod >> RecShift);
		mday_s3   <= {rem45[MdayW-LowW-1:0], low_s2};
		mday_s4   <= mday_s3;
		hour_s4   <= 5'(hour_prod >> RecShift);
		hour_s5   <= hour_s4;
		minute_s5 <= 6'(min_rem);
	end

	assign days   = days_s2;
	assign vld    = vld_s5;
	assign hour   = hour_s5;
	assign minute = minute_s5;

endmodule

[hdl/cma_month_roll.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cma_month_roll
// Stages 2-5: adds the carried days and rolls the date forward one month
// per stage. Two rolls cover every case: day <= 77 and any two consecutive
// months hold at least 59 days.
// -----------------------------------------------------------------------------
module cma_month_roll import cma_pkg::*; (
	input  logic             clk,
	input  cma_date_t        date,
	input  logic [DaysW-1:0] days,
	output cma_date_t        date_out
);

	localparam int unsigned DayW = 7;

	typedef struct packed {
		logic [DayW-1:0] day;
		logic [3:0]      month;
		logic [15:0]     year;
	} roll_t;

	// Fixed month lengths, no leap years
	function automatic logic [DayW-1:0] month_len(input logic [3:0] month);
		logic [DayW-1:0] len;
		case (month)
			4'd2:    len = DayW'(28);
			4'd4:    len = DayW'(30);
			4'd6:    len = DayW'(30);
			4'd9:    len = DayW'(30);
			4'd11:   len = DayW'(30);
			default: len = DayW'(31);
		endcase
		return len;
	endfunction

	// One month carry step; year wraps mod 65536
	function automatic roll_t roll_step(input roll_t cur);
		roll_t           nxt;
		logic [DayW-1:0] len;
		len = month_len(cur.month);
		nxt = cur;
		if (cur.day > len) begin
			nxt.day = cur.day - len;
			if (cur.month == 4'(MonthsInYear)) begin
				nxt.month = 4'd1;
				nxt.year  = cur.year + 16'd1;
			end else begin
				nxt.month = cur.month + 4'd1;
			end
		end
		return nxt;
	endfunction

	cma_date_t date_s2;
	roll_t     date_s3, date_s4, date_s5;

	always_ff @(posedge clk) begin
		date_s2       <= date;
		// Stage 3: add whole days
		date_s3.day   <= DayW'(date_s2.day) + DayW'(days);
		date_s3.month <= date_s2.month;
		date_s3.year  <= date_s2.year;
		// Stages 4 and 5: month carries
		date_s4       <= roll_step(date_s3);
		date_s5       <= roll_step(date_s4);
	end

	assign date_out.day   = date_s5.day[4:0];
	assign date_out.month = date_s5.month;
	assign date_out.year  = date_s5.year;

endmodule

[hdl/calendar_minute_advance.sv]
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; busy is always low and the pipeline
// has no stall path, since the receiver cannot hold results off.
// The latency is set by the two reciprocal multiply-and-remainder steps of the
// minute split and the two month carry stages that run beside them.
// Reset clears the stage valid bits only; no result is produced after reset.
// -----------------------------------------------------------------------------
// calendar_minute_advance
// Adds a number of minutes to a calendar date and time, five-stage pipeline.
// -----------------------------------------------------------------------------
module calendar_minute_advance import cma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cma_in_t  item,
	output logic     done,
	output cma_out_t result
);

	cma_sum_t         sum;
	cma_date_t        date_s1;
	cma_date_t        date_s5;
	logic [DaysW-1:0] days_s2;
	logic [4:0]       hour_s5;
	logic [5:0]       minute_s5;

	// Every cycle can take a transaction
	assign busy = 1'b0;

	cma_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.sum    (sum),
		.date   (date_s1)
	);

	cma_day_split u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.sum    (sum),
		.days   (days_s2),
		.vld    (done),
		.hour   (hour_s5),
		.minute (minute_s5)
	);

	cma_month_roll u_roll (
		.clk      (clk),
		.date     (date_s1),
		.days     (days_s2),
		.date_out (date_s5)
	);

	// Result assembly
	assign result.day_out    = date_s5.day;
	assign result.month_out  = date_s5.month;
	assign result.year_out   = date_s5.year;
	assign result.hour_out   = hour_s5;
	assign result.minute_out = minute_s5;

endmodule
